@@ rtl/core/sbq_pkg.sv @@
`default_nettype none

package sbq_pkg;

    // Fixed field widths.
    localparam int COEF_W    = 32;
    localparam int MIX_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_FRAC = 28;
    localparam int MIX_FRAC  = 16;
    localparam int STEP_W    = 4;

    localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX = 3'd5;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

    typedef logic [STEP_W-1:0] step_t;

    // Microprogram addresses.
    localparam step_t ST_IDLE     = 4'd0;
    localparam step_t ST_B0       = 4'd1;
    localparam step_t ST_B1       = 4'd2;
    localparam step_t ST_B2       = 4'd3;
    localparam step_t ST_A1       = 4'd4;
    localparam step_t ST_A2       = 4'd5;
    localparam step_t ST_FB_LAST  = 4'd6;
    localparam step_t ST_WET      = 4'd7;
    localparam step_t ST_MIX_DRY  = 4'd8;
    localparam step_t ST_MIX_WET  = 4'd9;
    localparam step_t ST_MIX_SUM  = 4'd10;
    localparam step_t ST_EMIT     = 4'd11;
    localparam step_t ST_PASS     = 4'd12;

    // Left multiplier operand.
    typedef enum logic [2:0] {
        CS_ZERO,
        CS_B0,
        CS_B1,
        CS_B2,
        CS_A1,
        CS_A2,
        CS_DRY_SHARE,
        CS_WET_SHARE
    } coef_sel_t;

    // Right multiplier operand.
    typedef enum logic [2:0] {
        SS_DRY,
        SS_X1,
        SS_X2,
        SS_Y1,
        SS_Y2,
        SS_WET
    } samp_sel_t;

    // Accumulator operation on the registered product.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_RND_WET,
        ACC_LOAD_RND_MIX,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    // Result actions.
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_WET,
        OUT_MIX,
        OUT_DRY
    } out_op_t;

    // Sequencing of the step counter.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_BRANCH_NOCH,
        SEQ_DONE
    } seq_op_t;

    typedef struct packed {
        coef_sel_t coef_sel;
        samp_sel_t samp_sel;
        acc_op_t   acc_op;
        out_op_t   out_op;
        seq_op_t   seq_op;
        step_t     target;
    } ctrl_word_t;

    // Microprogram: one control word per step.
    function automatic ctrl_word_t ucode(input step_t step);
        ctrl_word_t cw;
        cw = '{CS_ZERO, SS_DRY, ACC_HOLD, OUT_NONE, SEQ_NEXT, ST_IDLE};
        unique case (step)
            ST_IDLE:    cw = '{CS_ZERO, SS_DRY, ACC_HOLD, OUT_NONE, SEQ_WAIT_IN, ST_IDLE};
            ST_B0:      cw = '{CS_B0, SS_DRY, ACC_HOLD, OUT_NONE, SEQ_BRANCH_NOCH, ST_PASS};
            ST_B1:      cw = '{CS_B1, SS_X1, ACC_LOAD_RND_WET, OUT_NONE, SEQ_NEXT, ST_IDLE};
            ST_B2:      cw = '{CS_B2, SS_X2, ACC_ADD, OUT_NONE, SEQ_NEXT, ST_IDLE};
            ST_A1:      cw = '{CS_A1, SS_Y1, ACC_ADD, OUT_NONE, SEQ_NEXT, ST_IDLE};
            ST_A2:      cw = '{CS_A2, SS_Y2, ACC_SUB, OUT_NONE, SEQ_NEXT, ST_IDLE};
            ST_FB_LAST: cw = '{CS_ZERO, SS_DRY, ACC_SUB, OUT_NONE, SEQ_NEXT, ST_IDLE};
            ST_WET:     cw = '{CS_ZERO, SS_DRY, ACC_HOLD, OUT_WET, SEQ_NEXT, ST_IDLE};
            ST_MIX_DRY: cw = '{CS_DRY_SHARE, SS_DRY, ACC_HOLD, OUT_NONE, SEQ_NEXT, ST_IDLE};
            ST_MIX_WET: cw = '{CS_WET_SHARE, SS_WET, ACC_LOAD_RND_MIX, OUT_NONE, SEQ_NEXT,
                               ST_IDLE};
            ST_MIX_SUM: cw = '{CS_ZERO, SS_DRY, ACC_ADD, OUT_NONE, SEQ_NEXT, ST_IDLE};
            ST_EMIT:    cw = '{CS_ZERO, SS_DRY, ACC_HOLD, OUT_MIX, SEQ_DONE, ST_IDLE};
            ST_PASS:    cw = '{CS_ZERO, SS_DRY, ACC_HOLD, OUT_DRY, SEQ_DONE, ST_IDLE};
            default:    cw = '{CS_ZERO, SS_DRY, ACC_HOLD, OUT_NONE, SEQ_DONE, ST_IDLE};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sbq_in_if.sv @@
`default_nettype none

interface sbq_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           channel;
    logic                           block_end;

    modport source (output valid, output sample_in, output channel, output block_end,
                    input ready);
    modport sink (input valid, input sample_in, input channel, input block_end,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/sbq_out_if.sv @@
`default_nettype none

interface sbq_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           channel_out;
    logic                           block_end_out;

    modport source (output valid, output sample_out, output channel_out,
                    output block_end_out, input ready);
    modport sink (input valid, input sample_out, input channel_out, input block_end_out,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/sbq_cfg_if.sv @@
`default_nettype none

interface sbq_cfg_if;
    import sbq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/stereo_biquad_filter_mix.sv @@
// Per-channel direct form I biquad with a wet/dry mix.
// Channels: "samples" carries one dry sample with its channel number and a
// block end marker; "results" returns exactly one beat per sample, in order,
// with the channel and block end copied through. "cfg" writes the five Q4.28
// coefficients and the Q1.16 wet mix; it is always ready and must be used
// only while no sample is in flight.
// Sequence: a sample is taken in the idle step, then a microprogram drives one
// shared 32 x SAMPLE_WIDTH multiplier and an accumulator, one product per
// step. A filtered sample is written to the output register in the emit step;
// only then does the block go back to idle and take the next sample, so it
// never takes a new sample before it is through with the last. A channel
// number at or above CHANNELS skips the filter and leaves unfiltered.
// Reset loads the unity filter (b0 = 1.0, fully wet) and clears the delay
// lines of all channels.
// Stall: the result sits in an output register, so the next sample is taken
// while it waits; if the result is still not taken when the next one is
// done, the sequencer holds its last step until the register frees.
`default_nettype none

module stereo_biquad_filter_mix #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int CHANNELS     = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sbq_in_if.sink     samples,
    sbq_out_if.source  results,
    sbq_cfg_if.sink    cfg
);
    import sbq_pkg::*;

    localparam int PROD_W   = COEF_W + SAMPLE_WIDTH;
    localparam int ACC_W    = PROD_W + 3;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic signed [ACC_W-1:0] RND_WET = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] RND_MIX = ACC_W'(1) <<< (MIX_FRAC - 1);

    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Saturates a shifted accumulator value to the sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-SAMPLE_WIDTH:0] top;
        logic signed [SAMPLE_WIDTH-1:0] r;
        top = v[ACC_W-1:SAMPLE_WIDTH-1];
        if ((&top) || !(|top)) begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        else if (v[ACC_W-1]) begin
            r = SAT_LO;
        end
        else begin
            r = SAT_HI;
        end
        return r;
    endfunction

    // Configuration registers.
    logic signed [COEF_W-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [COEF_W-1:0] coef_a1_reg, coef_a2_reg;
    logic [MIX_W-1:0]         wet_mix_reg;

    // Per-channel delay lines.
    logic signed [SAMPLE_WIDTH-1:0] x1_reg [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] x2_reg [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] y1_reg [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] y2_reg [CHANNELS];

    // Sequencer and datapath.
    step_t                          step_reg, step_next;
    ctrl_word_t                     cw;
    logic signed [SAMPLE_WIDTH-1:0] dry_reg;
    logic                           ch_reg;
    logic                           block_end_reg;
    logic signed [SAMPLE_WIDTH-1:0] wet_reg;
    logic signed [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [COEF_W-1:0]       coef_op;
    logic signed [SAMPLE_WIDTH-1:0] samp_op;
    logic signed [SAMPLE_WIDTH-1:0] wet_next;
    logic signed [SAMPLE_WIDTH-1:0] mix_next;
    logic [MIX_W-1:0]               mix_clamped;
    logic [CH_IDX_W-1:0]            ch_idx;
    logic                           ch_ok;
    logic                           in_beat;
    logic                           emit_go;

    // Output register.
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                           channel_out_reg;
    logic                           block_end_out_reg;

    assign cw          = ucode(step_reg);
    assign ch_idx      = CH_IDX_W'(ch_reg);
    assign ch_ok       = (CHANNELS > 1) || !ch_reg;
    assign in_beat     = samples.valid && samples.ready;
    assign mix_clamped = (wet_mix_reg > MIX_ONE) ? MIX_ONE : wet_mix_reg;
    assign emit_go     = ((cw.out_op == OUT_MIX) || (cw.out_op == OUT_DRY))
                         && (!out_valid_reg || results.ready);

    assign samples.ready = (step_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;

    assign results.valid         = out_valid_reg;
    assign results.sample_out    = sample_out_reg;
    assign results.channel_out   = channel_out_reg;
    assign results.block_end_out = block_end_out_reg;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= COEF_ONE;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
            wet_mix_reg <= MIX_ONE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_COEF_B0: coef_b0_reg <= cfg.wdata;
                REG_COEF_B1: coef_b1_reg <= cfg.wdata;
                REG_COEF_B2: coef_b2_reg <= cfg.wdata;
                REG_COEF_A1: coef_a1_reg <= cfg.wdata;
                REG_COEF_A2: coef_a2_reg <= cfg.wdata;
                REG_WET_MIX: wet_mix_reg <= cfg.wdata[MIX_W-1:0];
                default:     ;
            endcase
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        unique case (cw.coef_sel)
            CS_B0:        coef_op = coef_b0_reg;
            CS_B1:        coef_op = coef_b1_reg;
            CS_B2:        coef_op = coef_b2_reg;
            CS_A1:        coef_op = coef_a1_reg;
            CS_A2:        coef_op = coef_a2_reg;
            CS_DRY_SHARE: coef_op = COEF_W'(MIX_ONE - mix_clamped);
            CS_WET_SHARE: coef_op = COEF_W'(mix_clamped);
            default:      coef_op = '0;
        endcase
        unique case (cw.samp_sel)
            SS_X1:   samp_op = x1_reg[ch_idx];
            SS_X2:   samp_op = x2_reg[ch_idx];
            SS_Y1:   samp_op = y1_reg[ch_idx];
            SS_Y2:   samp_op = y2_reg[ch_idx];
            SS_WET:  samp_op = wet_reg;
            default: samp_op = dry_reg;
        endcase
    end

    assign prod_next = coef_op * samp_op;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Accumulator update on the product of the previous step.
    always_comb
    begin
        unique case (cw.acc_op)
            ACC_LOAD_RND_WET: acc_next = prod_ext + RND_WET;
            ACC_LOAD_RND_MIX: acc_next = prod_ext + RND_MIX;
            ACC_ADD:          acc_next = acc_reg + prod_ext;
            ACC_SUB:          acc_next = acc_reg - prod_ext;
            default:          acc_next = acc_reg;
        endcase
    end

    // Rounded results from the accumulator.
    assign wet_next = sat_sample(acc_reg >>> COEF_FRAC);
    assign mix_next = sat_sample(acc_reg >>> MIX_FRAC);

    // Step counter with conditional jumps.
    always_comb
    begin
        step_next = step_reg;
        unique case (cw.seq_op)
            SEQ_WAIT_IN:
            begin
                if (in_beat)
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            SEQ_BRANCH_NOCH:
            begin
                step_next = ch_ok ? step_t'(step_reg + 1'b1) : cw.target;
            end
            SEQ_DONE:
            begin
                if (emit_go)
                begin
                    step_next = ST_IDLE;
                end
            end
            default:
            begin
                step_next = step_reg + 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (in_beat)
        begin
            dry_reg       <= samples.sample_in;
            ch_reg        <= samples.channel;
            block_end_reg <= samples.block_end;
        end
        if (cw.out_op == OUT_WET)
        begin
            wet_reg <= wet_next;
        end
    end

    // Delay lines shift once per filtered sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (cw.out_op == OUT_WET)
        begin
            x2_reg[ch_idx] <= x1_reg[ch_idx];
            x1_reg[ch_idx] <= dry_reg;
            y2_reg[ch_idx] <= y1_reg[ch_idx];
            y1_reg[ch_idx] <= wet_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            sample_out_reg    <= (cw.out_op == OUT_MIX) ? mix_next : dry_reg;
            channel_out_reg   <= ch_reg;
            block_end_out_reg <= block_end_reg;
        end
    end

endmodule

`default_nettype wire
